// ===== rtl/core/sh6_pkg.sv =====
// Shared types, constants and fixed-point helpers of the degree-6 spherical harmonics block.
package sh6_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int TURN_SHIFT    = 32 - ANGLE_BITS;
   localparam int OUT_FRAC_BITS = 16;
   localparam int OUT_SHIFT     = 30 - OUT_FRAC_BITS;
   localparam int OUT_W         = 18;
   localparam longint OUT_MAX   = 131071;
   localparam longint OUT_MIN_MAG = 131072;
   localparam longint OUT_ROUND = (OUT_SHIFT > 0) ? (longint'(1) << (OUT_SHIFT - 1)) : 0;

   // Width of a signed Q30 word inside the datapath.
   localparam int QW = 36;

   localparam int SIN_LAT  = 9;
   localparam int LEG_LAT  = 8;
   localparam int PIPE_LAT = SIN_LAT + LEG_LAT + 2;

   localparam logic [3:0] LAST_IDX = 4'd12;
   localparam logic [3:0] M_OFFSET = 4'd6;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;

   typedef logic signed [QW-1:0] q30_type;

   localparam q30_type ONE_Q30 = 36'sh0_4000_0000;

   typedef struct packed {
      logic              valid;
      logic signed [3:0] m;
      logic [2:0]        k;
      logic              flip;
      logic              last;
   } sh6_ctl_type;

   // Taylor magnitudes of sin(pi/2 x), Q30, for x, x^3, ... x^13.
   localparam logic [31:0] SIN_COEF [7] = '{
      32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995,
      32'd172272, 32'd3864, 32'd61
   };

   localparam logic [15:0] NORM_NUM [7] = '{
      16'd13, 16'd273, 16'd1365, 16'd1365, 16'd819, 16'd9009, 16'd3003
   };
   localparam int NORM_EXP [7] = '{10, 9, 12, 10, 11, 10, 12};

   // Square of the normalisation in Q60, rounded, then its integer square root.
   function automatic q30_type norm_const(input int k);
      logic [127:0] prod;
      logic [63:0]  v;
      logic [63:0]  res;
      logic [63:0]  bt;
      int           s;
      s    = 4 + NORM_EXP[k];
      prod = 128'(NORM_NUM[k]) * 128'(INV_PI_Q64);
      prod = prod + (128'(1) << (s - 1));
      v    = 64'(prod >> s);
      res  = '0;
      bt   = 64'(1) << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return q30_type'(res);
   endfunction

   localparam q30_type NORM_K [8] = '{
      norm_const(0), norm_const(1), norm_const(2), norm_const(3),
      norm_const(4), norm_const(5), norm_const(6), '0
   };

   // Unsigned Q30 product, rounded half up.
   function automatic logic [QW-1:0] umul_q30(input logic [QW-1:0] a, input logic [QW-1:0] b);
      logic [2*QW-1:0] p;
      p = (2*QW)'(a) * (2*QW)'(b) + ((2*QW)'(1) << 29);
      return p[QW+29:30];
   endfunction

   // Signed Q30 product, rounded half away from zero.
   function automatic q30_type smul(input q30_type a, input q30_type b);
      logic [QW-1:0] ua;
      logic [QW-1:0] ub;
      logic [QW-1:0] r;
      logic          neg;
      neg = a[QW-1] ^ b[QW-1];
      ua  = a[QW-1] ? QW'(-a) : QW'(a);
      ub  = b[QW-1] ? QW'(-b) : QW'(b);
      r   = umul_q30(ua, ub);
      return neg ? q30_type'(-r) : q30_type'(r);
   endfunction

endpackage

// ===== rtl/core/sh6_req_if.sv =====
// Input channel interface: angle pair with valid/ready handshake.
interface sh6_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] theta_turns;
   logic [15:0] phi_turns;

   modport source (output valid, output theta_turns, output phi_turns, input ready);
   modport sink (input valid, input theta_turns, input phi_turns, output ready);
endinterface

// ===== rtl/core/sh6_rsp_if.sv =====
// Result channel interface: one harmonic per item with valid/ready handshake.
interface sh6_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [3:0]  order_m;
   logic signed [17:0] real_part;
   logic signed [17:0] imag_part;
   logic               last_of_set;

   modport source (output valid, output order_m, output real_part, output imag_part,
                   output last_of_set, input ready);
   modport sink (input valid, input order_m, input real_part, input imag_part,
                 input last_of_set, output ready);
endinterface

// ===== rtl/core/spherical_harmonics_degree6.sv =====
// Top level of the degree-6 spherical harmonics pipeline.
//
//   channel  direction  item contents
//   req      in         theta_turns, phi_turns (unsigned turn fractions)
//   rsp      out        order_m, real_part, imag_part, last_of_set
//
// Each accepted angle pair issues thirteen orders, one per cycle while the
// result side is not stalled; the next pair is taken as the last order issues.
// A result passes 19 pipeline stages after the issue sequencer.
// Reset clears the sequencer's busy flag and counter and the stage control words only.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module spherical_harmonics_degree6 (
   input logic        clock,
   input logic        reset,
   sh6_req_if.sink    req,
   sh6_rsp_if.source  rsp
);
   import sh6_pkg::*;

   logic        en;
   sh6_ctl_type slot;
   logic [15:0] theta, phi;
   logic [31:0] tt, tp, tm;
   q30_type     sin_t, cos_t, sin_p, cos_p, v;
   sh6_ctl_type ctl_ff [0:PIPE_LAT-1];
   q30_type     cp_d_ff [0:LEG_LAT-1];
   q30_type     sp_d_ff [0:LEG_LAT-1];
   q30_type     re_ff, im_ff, re_in, im_in, im_prod;
   logic signed [OUT_W-1:0] real_ff, imag_ff;
   sh6_ctl_type mul_ctl;

   function automatic logic signed [OUT_W-1:0] to_out(input q30_type x);
      logic          neg;
      logic [QW:0]   u;
      neg = x[QW-1];
      u   = neg ? (QW+1)'(QW'(-x)) : (QW+1)'(QW'(x));
      u   = (u + (QW+1)'(OUT_ROUND)) >> OUT_SHIFT;
      if (neg) begin
         return (u > (QW+1)'(OUT_MIN_MAG)) ? OUT_W'(-OUT_MIN_MAG) : OUT_W'(-u);
      end
      return (u > (QW+1)'(OUT_MAX)) ? OUT_W'(OUT_MAX) : OUT_W'(u);
   endfunction

   assign en = !ctl_ff[PIPE_LAT-1].valid || rsp.ready;

   sh6_issue u_issue (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .req     (req),
      .slot_o  (slot),
      .theta_o (theta),
      .phi_o   (phi)
   );

   assign tt = 32'(theta) << TURN_SHIFT;
   assign tp = 32'(phi) << TURN_SHIFT;
   assign tm = 32'(tp * 32'(slot.k));

   sh6_sin u_sin_t (.clock(clock), .en(en), .turn_i(tt),                .sin_o(sin_t));
   sh6_sin u_cos_t (.clock(clock), .en(en), .turn_i(tt + QUARTER_TURN), .sin_o(cos_t));
   sh6_sin u_sin_p (.clock(clock), .en(en), .turn_i(tm),                .sin_o(sin_p));
   sh6_sin u_cos_p (.clock(clock), .en(en), .turn_i(tm + QUARTER_TURN), .sin_o(cos_p));

   sh6_leg u_leg (
      .clock  (clock),
      .en     (en),
      .s1_i   (sin_t),
      .c1_i   (cos_t),
      .k_i    (ctl_ff[SIN_LAT-1].k),
      .flip_i (ctl_ff[SIN_LAT-1].flip),
      .v_o    (v)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= slot;
         for (int i = 1; i < PIPE_LAT; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // The azimuth terms wait here until the amplitude catches up.
   always_ff @(posedge clock) begin
      if (en) begin
         cp_d_ff[0] <= cos_p;
         sp_d_ff[0] <= sin_p;
         for (int i = 1; i < LEG_LAT; i++) begin
            cp_d_ff[i] <= cp_d_ff[i-1];
            sp_d_ff[i] <= sp_d_ff[i-1];
         end
      end
   end

   assign mul_ctl = ctl_ff[SIN_LAT+LEG_LAT-1];
   assign im_prod = smul(v, sp_d_ff[LEG_LAT-1]);

   // The zonal order is taken as it stands: cos of a zero turn is not exactly one.
   always_comb begin
      if (mul_ctl.k == 3'd0) begin
         re_in = v;
         im_in = '0;
      end else begin
         re_in = smul(v, cp_d_ff[LEG_LAT-1]);
         im_in = mul_ctl.m[3] ? -im_prod : im_prod;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re_ff   <= re_in;
         im_ff   <= im_in;
         real_ff <= to_out(re_ff);
         imag_ff <= to_out(im_ff);
      end
   end

   assign rsp.valid       = ctl_ff[PIPE_LAT-1].valid;
   assign rsp.order_m     = ctl_ff[PIPE_LAT-1].m;
   assign rsp.last_of_set = ctl_ff[PIPE_LAT-1].last;
   assign rsp.real_part   = real_ff;
   assign rsp.imag_part   = imag_ff;

   a_zonal_imag: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.order_m == 4'sd0 |-> rsp.imag_part == '0)
      else $error("zonal harmonic left with a nonzero imaginary part");
   a_last_order: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.last_of_set == (rsp.order_m == 4'sd6)))
      else $error("last marker not on the top order");
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input taken while the result side is stalled");
endmodule

// ===== rtl/core/sh6_issue.sv =====
// Issue sequencer: holds one angle pair and issues its thirteen orders, one per cycle while en is high.
module sh6_issue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   sh6_req_if.sink              req,
   output sh6_pkg::sh6_ctl_type slot_o,
   output logic [15:0]          theta_o,
   output logic [15:0]          phi_o
);
   import sh6_pkg::*;

   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] theta_ff, phi_ff;
   logic        accept;
   logic signed [3:0] m;

   // No item is taken while reset is held, so none can be dropped by it.
   assign req.ready = !reset && en && (!busy_ff || cnt_ff == LAST_IDX);
   assign accept    = req.valid && req.ready;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (en && busy_ff) begin
         if (cnt_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         theta_ff <= req.theta_turns;
         phi_ff   <= req.phi_turns;
      end
   end

   assign m            = signed'(cnt_ff - M_OFFSET);
   assign slot_o.valid = busy_ff;
   assign slot_o.m     = m;
   assign slot_o.k     = m[3] ? 3'(-m) : 3'(m);
   assign slot_o.flip  = !m[3] && (m != 4'sd0) && m[0];
   assign slot_o.last  = (cnt_ff == LAST_IDX);
   assign theta_o      = theta_ff;
   assign phi_o        = phi_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> busy_ff && cnt_ff == '0)
      else $error("accepted item did not start at the first order");
   a_no_early_accept: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff != LAST_IDX |-> !req.ready)
      else $error("ready raised while a set was still being issued");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= LAST_IDX)
      else $error("order counter out of range");
endmodule

// ===== rtl/core/sh6_sin.sv =====
// Pipelined sine of a 32-bit turn: quadrant fold, Horner series, sign restore.
module sh6_sin (
   input  logic             clock,
   input  logic             en,
   input  logic [31:0]      turn_i,
   output sh6_pkg::q30_type sin_o
);
   import sh6_pkg::*;

   logic [30:0] x_in;
   logic [30:0] x_ff  [0:7];
   logic [30:0] x2_ff [1:6];
   logic [31:0] p_ff  [2:7];
   logic        neg_ff [0:7];
   logic [QW-1:0] mag;
   q30_type     out_ff;

   // Odd quadrants run the series on the mirrored remainder.
   assign x_in = turn_i[30] ? (31'h4000_0000 - {1'b0, turn_i[29:0]}) : {1'b0, turn_i[29:0]};

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= x_in;
         neg_ff[0] <= turn_i[31];
         x2_ff[1]  <= 31'(umul_q30(QW'(x_ff[0]), QW'(x_ff[0])));
         for (int j = 1; j <= 7; j++) begin
            x_ff[j]   <= x_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
         for (int j = 2; j <= 6; j++) begin
            x2_ff[j] <= x2_ff[j-1];
         end
         p_ff[2] <= SIN_COEF[5] - 32'(umul_q30(QW'(SIN_COEF[6]), QW'(x2_ff[1])));
         for (int j = 3; j <= 7; j++) begin
            p_ff[j] <= SIN_COEF[7-j] - 32'(umul_q30(QW'(p_ff[j-1]), QW'(x2_ff[j-1])));
         end
         out_ff <= neg_ff[7] ? q30_type'(-mag) : q30_type'(mag);
      end
   end

   assign mag   = umul_q30(QW'(x_ff[7]), QW'(p_ff[7]));
   assign sin_o = out_ff;
endmodule

// ===== rtl/core/sh6_leg.sv =====
// Pipelined Legendre amplitude: powers of cos and sin theta, polynomial, normalisation.
module sh6_leg (
   input  logic             clock,
   input  logic             en,
   input  sh6_pkg::q30_type s1_i,
   input  sh6_pkg::q30_type c1_i,
   input  logic [2:0]       k_i,
   input  logic             flip_i,
   output sh6_pkg::q30_type v_o
);
   import sh6_pkg::*;

   typedef logic signed [QW+5:0] pw_type;

   q30_type    cpw_ff [1:5][1:6];
   q30_type    spw_ff [1:5][1:6];
   logic [2:0] k_ff    [1:7];
   logic       flip_ff [1:7];
   q30_type    poly_ff, spow_ff, amp_ff, v_ff;
   pw_type     poly_in;
   q30_type    spow_in, kv;
   pw_type     c1, c2, c3, c4, c5, c6;

   always_ff @(posedge clock) begin
      if (en) begin
         cpw_ff[1][1] <= c1_i;
         spw_ff[1][1] <= s1_i;
         cpw_ff[1][2] <= smul(c1_i, c1_i);
         spw_ff[1][2] <= smul(s1_i, s1_i);
         k_ff[1]      <= k_i;
         flip_ff[1]   <= flip_i;
         for (int j = 2; j <= 5; j++) begin
            for (int p = 1; p <= j; p++) begin
               cpw_ff[j][p] <= cpw_ff[j-1][p];
               spw_ff[j][p] <= spw_ff[j-1][p];
            end
            cpw_ff[j][j+1] <= smul(cpw_ff[j-1][j], cpw_ff[j-1][1]);
            spw_ff[j][j+1] <= smul(spw_ff[j-1][j], spw_ff[j-1][1]);
         end
         for (int j = 2; j <= 7; j++) begin
            k_ff[j]    <= k_ff[j-1];
            flip_ff[j] <= flip_ff[j-1];
         end
         poly_ff <= q30_type'(poly_in);
         spow_ff <= spow_in;
         amp_ff  <= smul(spow_ff, poly_ff);
         v_ff    <= flip_ff[7] ? -kv : kv;
      end
   end

   assign c1 = pw_type'(cpw_ff[5][1]);
   assign c2 = pw_type'(cpw_ff[5][2]);
   assign c3 = pw_type'(cpw_ff[5][3]);
   assign c4 = pw_type'(cpw_ff[5][4]);
   assign c5 = pw_type'(cpw_ff[5][5]);
   assign c6 = pw_type'(cpw_ff[5][6]);

   always_comb begin
      case (k_ff[5])
         3'd0: begin
            poly_in = pw_type'(231) * c6 - pw_type'(315) * c4 + pw_type'(105) * c2
                      - pw_type'(5) * pw_type'(ONE_Q30);
            spow_in = ONE_Q30;
         end
         3'd1: begin
            poly_in = pw_type'(33) * c5 - pw_type'(30) * c3 + pw_type'(5) * c1;
            spow_in = spw_ff[5][1];
         end
         3'd2: begin
            poly_in = pw_type'(33) * c4 - pw_type'(18) * c2 + pw_type'(ONE_Q30);
            spow_in = spw_ff[5][2];
         end
         3'd3: begin
            poly_in = pw_type'(11) * c3 - pw_type'(3) * c1;
            spow_in = spw_ff[5][3];
         end
         3'd4: begin
            poly_in = pw_type'(11) * c2 - pw_type'(ONE_Q30);
            spow_in = spw_ff[5][4];
         end
         3'd5: begin
            poly_in = c1;
            spow_in = spw_ff[5][5];
         end
         3'd6: begin
            poly_in = pw_type'(ONE_Q30);
            spow_in = spw_ff[5][6];
         end
         default: begin
            poly_in = '0;
            spow_in = '0;
         end
      endcase
   end

   assign kv  = smul(NORM_K[k_ff[7]], amp_ff);
   assign v_o = v_ff;
endmodule
